// ----- design/mfwg_pkg.sv -----
`default_nettype none

package mfwg_pkg;

   // Sizes of the block.
   localparam int MAX_MEL_FILTERS   = 128;
   localparam int MAX_SPECTRUM_BINS = 4097;
   localparam int WEIGHT_FRAC_BITS  = 15;

   // Edge table geometry: filter f uses entries f, f+1 and f+2.
   localparam int EDGE_DEPTH      = MAX_MEL_FILTERS + 2;
   localparam int EDGE_ADDR_WIDTH = $clog2(EDGE_DEPTH);
   localparam int EDGE_WIDTH      = 16;

   // Field and register widths.
   localparam int SLOT_WIDTH        = 8;
   localparam int BIN_WIDTH         = 13;
   localparam int FILTER_WIDTH      = 7;
   localparam int MEL_COUNT_WIDTH   = 8;
   localparam int WEIGHT_WIDTH      = WEIGHT_FRAC_BITS + 1;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 13;

   // Divider: one quotient bit per step.
   localparam int DIV_STEPS      = WEIGHT_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS + 1);

   // Commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEL_FILTER_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPECTRUM_BIN_COUNT = 1'b1;

   // Reset values of the registers.
   localparam logic [MEL_COUNT_WIDTH-1:0] MEL_COUNT_RESET = 8'd40;
   localparam logic [BIN_WIDTH-1:0]       BIN_COUNT_RESET = 13'd257;

   typedef logic [EDGE_WIDTH-1:0] edge_type;

endpackage

`default_nettype wire

// ----- design/mfwg_req_if.sv -----
`default_nettype none

interface mfwg_req_if;
   import mfwg_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [SLOT_WIDTH-1:0]   edge_slot;
   logic signed [EDGE_WIDTH-1:0] edge_bin;
   logic [BIN_WIDTH-1:0]    spectrum_bin;
   logic [FILTER_WIDTH-1:0] filter_index;

   modport source (
      output valid, command, edge_slot, edge_bin, spectrum_bin, filter_index,
      input  ready
   );

   modport sink (
      input  valid, command, edge_slot, edge_bin, spectrum_bin, filter_index,
      output ready
   );

endinterface

`default_nettype wire

// ----- design/mfwg_rsp_if.sv -----
`default_nettype none

interface mfwg_rsp_if;
   import mfwg_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [WEIGHT_WIDTH-1:0] weight;
   logic                    status;

   modport source (
      output valid, weight, status,
      input  ready
   );

   modport sink (
      input  valid, weight, status,
      output ready
   );

endinterface

`default_nettype wire

// ----- design/mel_filterbank_weight_generator.sv -----
`default_nettype none

// Mel filterbank weight generator. Software loads the triangular filter edges
// (spectrogram bin indices, two's complement) into a 130-entry edge table with
// load beats; a load writes the table in the cycle of its beat and gives no
// response. A query beat names a bin and a filter and returns that filter's
// weight in unsigned Q1.15, truncated, with status 1 and weight 0 when the bin
// or filter lies beyond the configured counts. An in-range query whose bin lies
// on a side of the triangle passes from acceptance to the response through
// three reads through the single read port of the edge table, a setup state to
// pick the side of the triangle, sixteen steps of the radix-2 serial divider
// and a hand-over state. An in-range query that needs no division (a weight of
// one at a zero-width rising side, or zero off the triangle) skips the divider,
// and an out-of-range query goes straight to the hand-over state. The block is
// ready for the next beat in the cycle the response appears. One query is
// worked on at a time; a finished response waits in the output register while
// the next beat is accepted, and a second finished query stalls until that
// register is free. The edge table is not cleared by reset, so every entry a
// query uses must be loaded first.
module mel_filterbank_weight_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mfwg_req_if.sink                                  req_chan,
   mfwg_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mfwg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mfwg_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import mfwg_pkg::*;

   // Sequencer codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD_LO = 3'd1;
   localparam logic [2:0] ST_RD_CE = 3'd2;
   localparam logic [2:0] ST_RD_HI = 3'd3;
   localparam logic [2:0] ST_SETUP = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam int SX_WIDTH  = EDGE_WIDTH + 1;
   localparam int REM_WIDTH = EDGE_WIDTH + 1;

   logic [2:0]                 state_ff, state_in;
   logic [MEL_COUNT_WIDTH-1:0] mel_count_ff, mel_count_in;
   logic [BIN_WIDTH-1:0]       bin_count_ff, bin_count_in;
   logic [BIN_WIDTH-1:0]       bin_ff, bin_in;
   logic [FILTER_WIDTH-1:0]    filt_ff, filt_in;
   edge_type                   lo_ff, lo_in;
   edge_type                   ce_ff, ce_in;
   edge_type                   hi_ff, hi_in;
   logic [REM_WIDTH-1:0]       rem_ff, rem_in;
   logic [EDGE_WIDTH-1:0]      den_ff, den_in;
   logic [WEIGHT_WIDTH-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                       status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_WIDTH-1:0]    rsp_weight_ff, rsp_weight_in;
   logic                       rsp_status_ff, rsp_status_in;

   // Edge table and its read port.
   edge_type                   edge_mem [EDGE_DEPTH];
   edge_type                   rd_data_ff;
   logic                       rd_en;
   logic [EDGE_ADDR_WIDTH-1:0] rd_addr;
   logic                       wr_en;

   logic                       req_beat;
   logic [MEL_COUNT_WIDTH-1:0] mel_count_eff;
   logic [BIN_WIDTH-1:0]       bin_count_eff;
   logic                       range_err;
   logic signed [SX_WIDTH-1:0] j_sx, lo_sx, ce_sx, hi_sx;
   logic                       fall_side, rise_side, flat_one;
   logic [SX_WIDTH-1:0]        fall_num, fall_den, rise_num, rise_den;
   logic                       div_ge;
   logic [REM_WIDTH-1:0]       div_diff;
   logic                       slot_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.weight = rsp_weight_ff;
   assign rsp_chan.status = rsp_status_ff;

   // Counts above the table size are clamped.
   assign mel_count_eff = (mel_count_ff > MEL_COUNT_WIDTH'(MAX_MEL_FILTERS)) ?
                          MEL_COUNT_WIDTH'(MAX_MEL_FILTERS) : mel_count_ff;
   assign bin_count_eff = (bin_count_ff > BIN_WIDTH'(MAX_SPECTRUM_BINS)) ?
                          BIN_WIDTH'(MAX_SPECTRUM_BINS) : bin_count_ff;
   assign range_err = (req_chan.spectrum_bin >= bin_count_eff) ||
                      (MEL_COUNT_WIDTH'(req_chan.filter_index) >= mel_count_eff);

   // Loads write the table in the cycle of their beat.
   assign wr_en = req_beat && (req_chan.command == CMD_LOAD) &&
                  (int'(req_chan.edge_slot) < EDGE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         edge_mem[req_chan.edge_slot[EDGE_ADDR_WIDTH-1:0]] <= req_chan.edge_bin;
      end
      if (rd_en) begin
         rd_data_ff <= edge_mem[rd_addr];
      end
   end

   // Read address: lower edge on the query beat, then centre, then higher.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = EDGE_ADDR_WIDTH'(filt_ff);
      unique case (state_ff)
         ST_IDLE: begin
            rd_en   = req_beat && (req_chan.command == CMD_QUERY);
            rd_addr = EDGE_ADDR_WIDTH'(req_chan.filter_index);
         end
         ST_RD_LO: begin
            rd_en   = 1'b1;
            rd_addr = EDGE_ADDR_WIDTH'(filt_ff) + EDGE_ADDR_WIDTH'(1);
         end
         ST_RD_CE: begin
            rd_en   = 1'b1;
            rd_addr = EDGE_ADDR_WIDTH'(filt_ff) + EDGE_ADDR_WIDTH'(2);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Side selection on sign-extended edges and the query bin.
   assign j_sx  = $signed({{(SX_WIDTH-BIN_WIDTH){1'b0}}, bin_ff});
   assign lo_sx = $signed({lo_ff[EDGE_WIDTH-1], lo_ff});
   assign ce_sx = $signed({ce_ff[EDGE_WIDTH-1], ce_ff});
   assign hi_sx = $signed({hi_ff[EDGE_WIDTH-1], hi_ff});

   assign fall_side = (hi_sx > ce_sx) && (j_sx >= ce_sx) && (j_sx < hi_sx);
   assign rise_side = (ce_sx != lo_sx) && (j_sx >= lo_sx) && (j_sx <= ce_sx);
   assign flat_one  = (ce_sx == lo_sx) && (j_sx == ce_sx);
   assign fall_num  = SX_WIDTH'(hi_sx - j_sx);
   assign fall_den  = SX_WIDTH'(hi_sx - ce_sx);
   assign rise_num  = SX_WIDTH'(j_sx - lo_sx);
   assign rise_den  = SX_WIDTH'(ce_sx - lo_sx);

   // One restoring division step: the remainder left after the subtraction stays below the divisor.
   assign div_ge   = (rem_ff >= {1'b0, den_ff});
   assign div_diff = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      mel_count_in  = mel_count_ff;
      bin_count_in  = bin_count_ff;
      bin_in        = bin_ff;
      filt_in       = filt_ff;
      lo_in         = lo_ff;
      ce_in         = ce_ff;
      hi_in         = hi_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            REG_MEL_FILTER_COUNT:   mel_count_in = csr_write_data[MEL_COUNT_WIDTH-1:0];
            REG_SPECTRUM_BIN_COUNT: bin_count_in = csr_write_data[BIN_WIDTH-1:0];
            default:                mel_count_in = mel_count_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_chan.command == CMD_QUERY)) begin
               bin_in  = req_chan.spectrum_bin;
               filt_in = req_chan.filter_index;
               if (range_err) begin
                  quo_in    = '0;
                  status_in = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  status_in = 1'b0;
                  state_in  = ST_RD_LO;
               end
            end
         end
         ST_RD_LO: begin
            lo_in    = rd_data_ff;
            state_in = ST_RD_CE;
         end
         ST_RD_CE: begin
            ce_in    = rd_data_ff;
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            hi_in    = rd_data_ff;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cnt_in = DIV_CNT_WIDTH'(DIV_STEPS);
            quo_in = '0;
            if (fall_side) begin
               rem_in   = REM_WIDTH'(fall_num);
               den_in   = fall_den[EDGE_WIDTH-1:0];
               state_in = ST_DIV;
            end else if (rise_side) begin
               rem_in   = REM_WIDTH'(rise_num);
               den_in   = rise_den[EDGE_WIDTH-1:0];
               state_in = ST_DIV;
            end else begin
               quo_in   = flat_one ? (WEIGHT_WIDTH'(1) << WEIGHT_FRAC_BITS) : '0;
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            rem_in = {div_diff[REM_WIDTH-2:0], 1'b0};
            quo_in = {quo_ff[WEIGHT_WIDTH-2:0], div_ge};
            cnt_in = cnt_ff - DIV_CNT_WIDTH'(1);
            if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = quo_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mel_count_ff <= MEL_COUNT_RESET;
         bin_count_ff <= BIN_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mel_count_ff <= mel_count_in;
         bin_count_ff <= bin_count_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bin_ff        <= bin_in;
      filt_ff       <= filt_in;
      lo_ff         <= lo_in;
      ce_ff         <= ce_in;
      hi_ff         <= hi_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      status_ff     <= status_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The divider count never runs past the number of quotient bits.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_CNT_WIDTH'(DIV_STEPS)) && (cnt_ff != '0))
      else $error("divider count out of range");

   // A new response beat only appears after the hand-over state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside hand-over");

   // An error response always carries a zero weight.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_weight_ff == '0))
      else $error("error response with non-zero weight");

   // No weight exceeds one.
   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_weight_ff <= (WEIGHT_WIDTH'(1) << WEIGHT_FRAC_BITS)))
      else $error("weight above one");

endmodule

`default_nettype wire

// ----- tb/tb_mel_filterbank_weight_generator.sv -----
`default_nettype none

module tb_mel_filterbank_weight_generator;
   import mfwg_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 30;
   localparam int LONG_HOLD     = 600;
   localparam int PHASES        = 8;
   localparam int HOLD_PHASE    = 4;
   localparam int BIN_FIELD_MAX = (1 << BIN_WIDTH) - 1;

   // One request beat as the sender sees it.
   typedef struct {
      logic                    command;
      logic [SLOT_WIDTH-1:0]   edge_slot;
      logic [EDGE_WIDTH-1:0]   edge_bin;
      logic [BIN_WIDTH-1:0]    spectrum_bin;
      logic [FILTER_WIDTH-1:0] filter_index;
   } mel_beat_type;

   // One response beat.
   typedef struct {
      logic [WEIGHT_WIDTH-1:0] weight;
      logic                    status;
   } weight_rsp_type;

   logic clock;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   mfwg_req_if req_if ();
   mfwg_rsp_if rsp_if ();

   mel_filterbank_weight_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: the edge store and the two count registers.
   edge_type    edge_mem [EDGE_DEPTH];
   int unsigned cfg_mel_count = MEL_COUNT_RESET;
   int unsigned cfg_bin_count = BIN_COUNT_RESET;

   // Stimulus bookkeeping.
   mel_beat_type   pending_beats [$];
   weight_rsp_type expected_weights [$];
   mel_beat_type   cur_beat;
   bit          slot_loaded [EDGE_DEPTH];
   int          beat_total;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          req_gap;
   int          rsp_gap;
   int          hold_left;
   bit          long_hold_req;
   int          err_count;
   int          cycle_count;

   int unsigned phase_mel   [PHASES] = '{128, 255, 1, 0, 129, 0, 40, 128};
   int unsigned phase_bins  [PHASES] = '{4097, 8191, 2, 0, 4098, 0, 257, 1};
   int          phase_beats [PHASES] = '{240, 240, 200, 100, 240, 240, 240, 240};
   int          phase_req   [PHASES] = '{20, 0, 30, 10, 25, 50, 15, 40};
   int          phase_rsp   [PHASES] = '{20, 0, 30, 10, 25, 50, 15, 40};

   // Clock, and every block input held at a known value from time zero.
   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_LOAD;
      req_if.edge_slot    = '0;
      req_if.edge_bin     = '0;
      req_if.spectrum_bin = '0;
      req_if.filter_index = '0;
      rsp_if.ready        = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int eff_filters();
      return (cfg_mel_count > MAX_MEL_FILTERS) ? MAX_MEL_FILTERS : int'(cfg_mel_count);
   endfunction

   function automatic int eff_bins();
      return (cfg_bin_count > MAX_SPECTRUM_BINS) ? MAX_SPECTRUM_BINS : int'(cfg_bin_count);
   endfunction

   // Truncated num/den in unsigned fixed point.
   function automatic longint frac_q(int num, int den);
      longint n;
      longint d;
      n = num;
      d = den;
      return (n << WEIGHT_FRAC_BITS) / d;
   endfunction

   // Expected response for a query: the triangle's weight, or an error status.
   function automatic weight_rsp_type predict_weight(logic [BIN_WIDTH-1:0] bin,
                                                     logic [FILTER_WIDTH-1:0] filt);
      weight_rsp_type r;
      int          fi;
      int          lo;
      int          ce;
      int          hi;
      int          j;
      longint      w;
      r.weight = '0;
      r.status = 1'b1;
      fi = int'(filt);
      j  = int'(bin);
      if (j >= eff_bins() || fi >= eff_filters()) return r;
      lo = int'($signed(edge_mem[fi]));
      ce = int'($signed(edge_mem[fi + 1]));
      hi = int'($signed(edge_mem[fi + 2]));
      w  = 0;
      // A rising side of zero width counts only at the centre itself.
      if (ce == lo) begin
         if (j == ce) w = longint'(1) << WEIGHT_FRAC_BITS;
      end else if (j >= lo && j <= ce) begin
         w = frac_q(j - lo, ce - lo);
      end
      // The falling side wins where both sides apply.
      if (hi > ce && j >= ce && j < hi) w = frac_q(hi - j, hi - ce);
      r.weight = w[WEIGHT_WIDTH-1:0];
      r.status = 1'b0;
      return r;
   endfunction

   function automatic int idle_len(int pct);
      if (int'($urandom_range(0, 99)) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   function automatic int clip_edge(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // Width of one side of a triangle; negative widths give inverted edges.
   function automatic int side_width();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 10) return -int'($urandom_range(1, 50));
      if (r < 25) return 0;
      if (r < 65) return int'($urandom_range(1, 16));
      if (r < 92) return int'($urandom_range(17, 400));
      return int'($urandom_range(401, 6000));
   endfunction

   task automatic push_load(int slot, int value);
      mel_beat_type b;
      b.command      = CMD_LOAD;
      b.edge_slot    = SLOT_WIDTH'(slot);
      b.edge_bin     = EDGE_WIDTH'(value);
      b.spectrum_bin = BIN_WIDTH'($urandom);
      b.filter_index = FILTER_WIDTH'($urandom);
      pending_beats.push_back(b);
      // Loads beyond the store are ignored by the block and not counted.
      if (int'(b.edge_slot) < EDGE_DEPTH) begin
         slot_loaded[b.edge_slot] = 1'b1;
         beat_total++;
      end
   endtask

   // An in-range query must never read an entry that was never loaded.
   task automatic push_query(int bin, int filt);
      mel_beat_type b;
      int        jb;
      jb = (bin < 0) ? 0 : ((bin > BIN_FIELD_MAX) ? BIN_FIELD_MAX : bin);
      if (jb < eff_bins() && filt < eff_filters()) begin
         for (int k = 0; k < 3; k++)
            if (!slot_loaded[filt + k]) push_load(filt + k, int'($urandom_range(0, 65535)));
      end
      b.command      = CMD_QUERY;
      b.edge_slot    = SLOT_WIDTH'($urandom);
      b.edge_bin     = EDGE_WIDTH'($urandom);
      b.spectrum_bin = BIN_WIDTH'(jb);
      b.filter_index = FILTER_WIDTH'(filt);
      pending_beats.push_back(b);
      beat_total++;
   endtask

   // Load one filter's lower, centre and higher edges, then ask about bins around the triangle.
   task automatic push_triangle();
      int lim;
      int filt;
      int lo;
      int ce;
      int hi;
      int bottom;
      int top;
      int b;
      lim  = (eff_bins() > 1) ? eff_bins() : 2;
      filt = (eff_filters() > 0) ? int'($urandom_range(0, eff_filters() - 1))
                                 : int'($urandom_range(0, 127));
      lo = int'($urandom_range(0, lim - 1)) - int'($urandom_range(0, 4));
      if ($urandom_range(0, 31) == 0) lo = -32768 + int'($urandom_range(0, 3));
      lo = clip_edge(lo);
      ce = clip_edge(lo + side_width());
      hi = clip_edge(ce + side_width());
      if ($urandom_range(0, 31) == 0) hi = 32767;
      push_load(filt, lo);
      push_load(filt + 1, ce);
      push_load(filt + 2, hi);
      bottom = (lo < ce) ? lo : ce;
      bottom = (hi < bottom) ? hi : bottom;
      top    = (lo > ce) ? lo : ce;
      top    = (hi > top) ? hi : top;
      repeat ($urandom_range(2, 6)) begin
         case ($urandom_range(0, 5))
            0: b = lo;
            1: b = ce;
            2: b = hi;
            3: b = ce + (($urandom_range(0, 1) == 0) ? -1 : 1);
            4: b = int'($urandom_range(0, lim - 1));
            default: b = bottom - 1 + int'($urandom_range(0, top - bottom + 2));
         endcase
         push_query(b, filt);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_WIDTH'(val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_MEL_FILTER_COUNT) cfg_mel_count = val & 32'hFF;
      else cfg_bin_count = val & 32'h1FFF;
   endtask

   // Wait until every beat is sent and answered, then let a trailing load finish.
   task automatic drain_and_settle();
      while (pending_beats.size() != 0 || req_if.valid || expected_weights.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: holds a beat until it is taken, then idles for a random gap.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (cur_beat.command == CMD_LOAD) begin
               if (int'(cur_beat.edge_slot) < EDGE_DEPTH)
                  edge_mem[cur_beat.edge_slot] = cur_beat.edge_bin;
            end else begin
               expected_weights.push_back(predict_weight(cur_beat.spectrum_bin,
                                                         cur_beat.filter_index));
            end
         end
         if (req_if.valid && !req_if.ready) begin
            next_valid = 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
            next_valid = 1'b0;
         end else if (pending_beats.size() != 0) begin
            cur_beat = pending_beats.pop_front();
            req_if.command      <= cur_beat.command;
            req_if.edge_slot    <= cur_beat.edge_slot;
            req_if.edge_bin     <= cur_beat.edge_bin;
            req_if.spectrum_bin <= cur_beat.spectrum_bin;
            req_if.filter_index <= cur_beat.filter_index;
            next_valid = 1'b1;
            req_gap = idle_len(req_idle_pct);
         end else begin
            next_valid = 1'b0;
         end
         req_if.valid <= next_valid;
      end
   end

   // Response ready: random gaps, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap   = 0;
         hold_left = 0;
      end else begin
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap = idle_len(rsp_idle_pct);
         end
      end
   end

   // Response monitor: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      weight_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_weights.size() == 0) begin
            $error("unexpected response beat: weight %0d, status %0d",
                   rsp_if.weight, rsp_if.status);
            err_count++;
         end else begin
            want = expected_weights.pop_front();
            if (rsp_if.weight !== want.weight) begin
               $error("weight mismatch: expected %0d, actual %0d", want.weight, rsp_if.weight);
               err_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int pick;
      phase_mel[5]  = $urandom_range(1, 127);
      phase_bins[5] = $urandom_range(1, 4096);
      req_idle_pct  = 15;
      rsp_idle_pct  = 15;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed beats under the reset counts of 40 filters and 257 bins.
      push_load(0, -32768);
      push_load(1, 10);
      push_load(2, 20);
      push_query(0, 0);
      push_query(10, 0);
      push_query(15, 0);
      push_query(20, 0);
      push_query(256, 0);
      push_query(257, 0);
      // Largest edge value, long falling side.
      push_load(3, 32767);
      push_query(19, 1);
      push_query(200, 1);
      // Zero-width rising side, and inverted edges in the filter below it.
      push_load(4, 30);
      push_load(5, 30);
      push_load(6, 40);
      push_query(30, 4);
      push_query(29, 4);
      push_query(35, 4);
      push_query(30, 3);
      // Last slot of the store, and slots beyond it which are ignored.
      push_load(129, 5000);
      push_load(130, 1);
      push_load(255, -1);
      push_query(0, 127);
      push_query(BIN_FIELD_MAX, 0);
      push_query(100, 39);
      drain_and_settle();

      // Random phases, each under its own pair of counts.
      for (int p = 0; p < PHASES; p++) begin
         write_csr(REG_MEL_FILTER_COUNT, phase_mel[p]);
         write_csr(REG_SPECTRUM_BIN_COUNT, phase_bins[p]);
         @(negedge clock);
         req_idle_pct = phase_req[p];
         rsp_idle_pct = phase_rsp[p];
         beat_total   = 0;
         // The last bin in range and the first one beyond it.
         push_query(eff_bins() - 1, int'($urandom_range(0, 127)));
         push_query(eff_bins(), int'($urandom_range(0, 127)));
         while (beat_total < phase_beats[p]) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 65) push_triangle();
            else if (pick < 85) push_load(int'($urandom_range(0, 255)),
                                          int'($urandom_range(0, 65535)));
            else push_query(int'($urandom_range(0, BIN_FIELD_MAX)),
                            int'($urandom_range(0, 127)));
         end
         // Hold responses back long enough for the request side to stall.
         if (p == HOLD_PHASE) long_hold_req = 1'b1;
         drain_and_settle();
      end

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
